// File: rtl/core/calibrated_window_mean_median_filter_assert.svh
`ifndef CALIBRATED_WINDOW_MEAN_MEDIAN_FILTER_ASSERT_SVH
`define CALIBRATED_WINDOW_MEAN_MEDIAN_FILTER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CWMF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CWMF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cwmf_pkg.sv
`timescale 1ns / 1ps

package cwmf_pkg;

    localparam int DW       = 16;
    localparam int GAIN_W   = 16;
    localparam int LEN_W    = 5;
    localparam int CFG_W    = 16;
    localparam int CAL_FRAC = 14;
    localparam int CAL_HALF = 1 << (CAL_FRAC - 1);
    localparam int SAT_MAX  = 32767;
    localparam int SAT_MIN  = -32768;

    localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd15860;
    localparam logic [DW-1:0]     OFFSET_RST = 16'hFD9A;
    localparam logic [LEN_W-1:0]  LEN_RST    = 5'd5;

    typedef enum logic [1:0] {
        CFG_GAIN   = 2'd0,
        CFG_OFFSET = 2'd1,
        CFG_LEN    = 2'd2,
        CFG_MEDIAN = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [DW-1:0]     offset;
    } t_cal_cfg;

endpackage

// File: rtl/core/calibrated_window_mean_median_filter.sv
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// input     i_in_valid / o_in_ready      i_sample
// output    o_out_valid / i_out_ready    o_calibrated, o_filtered
// config    i_cfg_we                     i_cfg_idx, i_cfg_data
//
// One request at a time; the calibration pipeline runs through S_MUL and S_SAT, and S_WR writes the window.
// Mean: S_SUM adds the n valid entries, S_NEG takes the magnitude, S_DIV divides by n, S_FIX restores the sign.
// Median: each candidate is ranked in S_MSCAN, one compare per cycle through the shared adder.
// Reset is synchronous and active low; the window is read only where it has been written.
// A finished result waits in the output register while the next request is taken.

module calibrated_window_mean_median_filter #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [cwmf_pkg::DW-1:0]    i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [cwmf_pkg::DW-1:0]    o_calibrated,
    output logic signed [cwmf_pkg::DW-1:0]    o_filtered,
    input  logic                              i_cfg_we,
    input  cwmf_pkg::t_cfg_idx                i_cfg_idx,
    input  logic [cwmf_pkg::CFG_W-1:0]        i_cfg_data
);
    import cwmf_pkg::*;

`include "calibrated_window_mean_median_filter_assert.svh"

    localparam int PW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int AW = DW + CW;
    localparam int XW = AW + 1;
    localparam int SW = $clog2(AW + 1);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MUL   = 13'b0000000000010,
        S_SAT   = 13'b0000000000100,
        S_WR    = 13'b0000000001000,
        S_SUM   = 13'b0000000010000,
        S_NEG   = 13'b0000000100000,
        S_DIV   = 13'b0000001000000,
        S_FIX   = 13'b0000010000000,
        S_MCAND = 13'b0000100000000,
        S_MLOAD = 13'b0001000000000,
        S_MSCAN = 13'b0010000000000,
        S_MCHK  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    function automatic logic [CW-1:0] f_eff_len(input logic [LEN_W-1:0] len);
        logic [CW-1:0] res;
        if (len == '0) begin
            res = CW'(1);
        end else if (32'(len) > 32'(MAX_WINDOW)) begin
            res = CW'(MAX_WINDOW);
        end else begin
            res = CW'(len);
        end
        return res;
    endfunction

    t_state                 r_state;
    t_state                 n_state;
    t_cal_cfg               r_cal_cfg;
    logic [CW-1:0]          r_len_eff;
    logic                   r_median;
    logic [PW-1:0]          r_wp;
    logic [CW-1:0]          r_cnt;
    logic signed [DW-1:0]   r_sample;
    logic signed [DW-1:0]   w_cal;
    logic signed [DW-1:0]   r_mem [MAX_WINDOW];
    logic signed [DW-1:0]   r_rd_data;
    logic [PW-1:0]          w_rd_addr;
    logic [CW-1:0]          r_idx;
    logic                   r_rd_ok;
    logic                   w_issue;
    logic signed [AW-1:0]   r_acc;
    logic                   r_neg;
    logic [CW-1:0]          r_rem;
    logic [SW-1:0]          r_step;
    logic [PW-1:0]          r_ci;
    logic signed [DW-1:0]   r_cand;
    logic [CW-1:0]          r_lt;
    logic [CW-1:0]          r_le;
    logic [CW-1:0]          w_wp_inc;
    logic [CW-1:0]          w_half;
    logic                   w_found;
    logic                   w_scan_end;
    logic                   w_load_out;
    logic signed [XW-1:0]   w_alu_a;
    logic signed [XW-1:0]   w_alu_b;
    logic                   w_alu_sub;
    logic signed [XW-1:0]   w_alu;
    logic signed [XW-1:0]   w_rd_x;
    logic                   r_out_valid;
    logic signed [DW-1:0]   r_out_cal;
    logic signed [DW-1:0]   r_out_filt;

    cwmf_cal u_cal (
        .i_clk    (i_clk),
        .i_cfg    (r_cal_cfg),
        .i_sample (r_sample),
        .o_cal    (w_cal)
    );

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_calibrated = r_out_cal;
    assign o_filtered   = r_out_filt;

    assign w_wp_inc   = CW'(r_wp) + CW'(1);
    assign w_half     = r_cnt >> 1;
    assign w_issue    = (r_idx != r_cnt);
    assign w_scan_end = !w_issue && !r_rd_ok;
    assign w_found    = (r_lt <= w_half) && (w_half < r_le);
    assign w_load_out = !r_out_valid || i_out_ready;
    assign w_rd_x     = {{(XW-DW){r_rd_data[DW-1]}}, r_rd_data};

    always_comb begin
        if (r_state == S_MCAND) begin
            w_rd_addr = r_ci;
        end else if (w_issue) begin
            w_rd_addr = r_idx[PW-1:0];
        end else begin
            w_rd_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            r_mem[r_wp] <= w_cal;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Shared adder: accumulation, negation, division steps and median compares.
    always_comb begin
        w_alu_a   = '0;
        w_alu_b   = '0;
        w_alu_sub = 1'b1;
        case (r_state)
            S_SUM: begin
                w_alu_a   = XW'(r_acc);
                w_alu_b   = w_rd_x;
                w_alu_sub = 1'b0;
            end
            S_NEG, S_FIX: begin
                w_alu_b = XW'(r_acc);
            end
            S_DIV: begin
                w_alu_a = $signed(XW'({r_rem, r_acc[AW-1]}));
                w_alu_b = $signed(XW'(r_cnt));
            end
            S_MSCAN: begin
                w_alu_a = w_rd_x;
                w_alu_b = {{(XW-DW){r_cand[DW-1]}}, r_cand};
            end
            default: begin
                w_alu_a = '0;
            end
        endcase
    end

    assign w_alu = w_alu_sub ? (w_alu_a - w_alu_b) : (w_alu_a + w_alu_b);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_MUL;
            S_MUL:   n_state = S_SAT;
            S_SAT:   n_state = S_WR;
            S_WR:    n_state = r_median ? S_MCAND : S_SUM;
            S_SUM:   if (w_scan_end) n_state = S_NEG;
            S_NEG:   n_state = S_DIV;
            S_DIV:   if (r_step == SW'(AW - 1)) n_state = S_FIX;
            S_FIX:   n_state = S_DONE;
            S_MCAND: n_state = S_MLOAD;
            S_MLOAD: n_state = S_MSCAN;
            S_MSCAN: if (w_scan_end) n_state = S_MCHK;
            S_MCHK:  n_state = w_found ? S_DONE : S_MCAND;
            S_DONE:  if (w_load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_cal_cfg.gain  <= GAIN_RST;
            r_cal_cfg.offset <= OFFSET_RST;
            r_len_eff       <= f_eff_len(LEN_RST);
            r_median        <= 1'b0;
            r_wp            <= '0;
            r_cnt           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN:   r_cal_cfg.gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_OFFSET: r_cal_cfg.offset <= i_cfg_data[DW-1:0];
                    CFG_LEN: begin
                        r_len_eff <= f_eff_len(i_cfg_data[LEN_W-1:0]);
                        r_wp      <= '0;
                        r_cnt     <= '0;
                    end
                    CFG_MEDIAN: r_median <= i_cfg_data[0];
                    default:    r_median <= r_median;
                endcase
            end
            if (r_state == S_WR) begin
                r_wp <= (w_wp_inc == r_len_eff) ? '0 : w_wp_inc[PW-1:0];
                if (r_cnt < r_len_eff) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
            if (r_state == S_DONE && w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_sample <= i_sample;
                end
            end
            S_WR: begin
                r_idx   <= '0;
                r_rd_ok <= 1'b0;
                r_acc   <= '0;
                r_ci    <= '0;
            end
            S_SUM: begin
                if (r_rd_ok) begin
                    r_acc <= w_alu[AW-1:0];
                end
                if (w_issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                r_rd_ok <= w_issue;
            end
            S_NEG: begin
                r_neg  <= r_acc[AW-1];
                r_rem  <= '0;
                r_step <= '0;
                if (r_acc[AW-1]) begin
                    r_acc <= w_alu[AW-1:0];
                end
            end
            S_DIV: begin
                r_step <= r_step + SW'(1);
                r_acc  <= {r_acc[AW-2:0], ~w_alu[XW-1]};
                if (!w_alu[XW-1]) begin
                    r_rem <= w_alu[CW-1:0];
                end else begin
                    r_rem <= {r_rem[CW-2:0], r_acc[AW-1]};
                end
            end
            S_FIX: begin
                if (r_neg) begin
                    r_acc <= w_alu[AW-1:0];
                end
            end
            S_MLOAD: begin
                r_cand  <= r_rd_data;
                r_idx   <= '0;
                r_rd_ok <= 1'b0;
                r_lt    <= '0;
                r_le    <= '0;
            end
            S_MSCAN: begin
                if (r_rd_ok) begin
                    if (w_alu[XW-1]) begin
                        r_lt <= r_lt + CW'(1);
                        r_le <= r_le + CW'(1);
                    end else if (w_alu == '0) begin
                        r_le <= r_le + CW'(1);
                    end
                end
                if (w_issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                r_rd_ok <= w_issue;
            end
            S_MCHK: begin
                if (w_found) begin
                    r_acc <= AW'(r_cand);
                end else begin
                    r_ci <= r_ci + PW'(1);
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    r_out_cal  <= w_cal;
                    r_out_filt <= r_acc[DW-1:0];
                end
            end
            default: begin
                r_rd_ok <= r_rd_ok;
            end
        endcase
    end

    `CWMF_ASSERT_IMP(a_cnt_in_len, i_clk, i_rst_n, 1'b1,
        r_cnt <= r_len_eff && CW'(r_wp) < r_len_eff, "window count or pointer beyond length")
    `CWMF_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready,
        r_state == S_MUL && !o_in_ready, "accepted request did not start calibration")
    `CWMF_ASSERT_IMP(a_div_rem, i_clk, i_rst_n, r_state == S_DIV,
        r_rem < r_cnt && r_cnt != '0, "divider remainder not below divisor")
    `CWMF_ASSERT_IMP(a_med_rank, i_clk, i_rst_n, r_state == S_MCHK,
        r_le > r_lt, "median candidate not counted against itself")
    `CWMF_ASSERT_IMP(a_med_cand, i_clk, i_rst_n, r_state == S_MCAND,
        CW'(r_ci) < r_cnt, "median search ran past the valid entries")

endmodule

// File: rtl/core/cwmf_cal.sv
`timescale 1ns / 1ps

module cwmf_cal (
    input  logic                            i_clk,
    input  cwmf_pkg::t_cal_cfg              i_cfg,
    input  logic signed [cwmf_pkg::DW-1:0]  i_sample,
    output logic signed [cwmf_pkg::DW-1:0]  o_cal
);
    import cwmf_pkg::*;

    localparam int PROD_W = DW + GAIN_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SHR_W  = SUM_W - CAL_FRAC;
    localparam int OUT_W  = SHR_W + 1;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  w_round;
    logic signed [SHR_W-1:0]  w_scaled;
    logic signed [OUT_W-1:0]  w_sum;
    logic signed [DW-1:0]     w_sat;
    logic signed [DW-1:0]     r_cal;

    assign w_prod = PROD_W'(i_sample) * PROD_W'($signed({1'b0, i_cfg.gain}));

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    // Round half up to the Q8.8 step, then add the offset and clamp.
    assign w_round  = SUM_W'(r_prod) + SUM_W'(CAL_HALF);
    assign w_scaled = SHR_W'(w_round >>> CAL_FRAC);
    assign w_sum    = OUT_W'(w_scaled) + OUT_W'($signed(i_cfg.offset));

    always_comb begin
        if (w_sum > OUT_W'(SAT_MAX)) begin
            w_sat = DW'(SAT_MAX);
        end else if (w_sum < OUT_W'(SAT_MIN)) begin
            w_sat = DW'(SAT_MIN);
        end else begin
            w_sat = w_sum[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cal <= w_sat;
    end

    assign o_cal = r_cal;

endmodule

// File: sim/tb_calibrated_window_mean_median_filter.sv
`timescale 1ns / 1ps

module tb_calibrated_window_mean_median_filter;

    localparam int WIN_MAX = 16;

    typedef logic signed [cwmf_pkg::DW-1:0] q88_t;

    typedef struct {
        q88_t cal;
        q88_t filt;
    } filter_pair_t;

    class cal_filter_tracker;
        logic [cwmf_pkg::GAIN_W-1:0] gain;
        q88_t                        offset;
        logic [cwmf_pkg::LEN_W-1:0]  length;
        bit                          median;
        q88_t                        store [WIN_MAX];
        int unsigned                 next_slot;
        int unsigned                 filled;
        filter_pair_t                expected_pairs [$];
        int unsigned                 errors;

        function new();
            gain      = cwmf_pkg::GAIN_RST;
            offset    = cwmf_pkg::OFFSET_RST;
            length    = cwmf_pkg::LEN_RST;
            median    = 1'b0;
            next_slot = 0;
            filled    = 0;
            errors    = 0;
            foreach (store[i]) store[i] = '0;
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        function void write_reg(cwmf_pkg::t_cfg_idx idx, logic [cwmf_pkg::CFG_W-1:0] data);
            case (idx)
                cwmf_pkg::CFG_GAIN: begin
                    gain = data;
                end
                cwmf_pkg::CFG_OFFSET: begin
                    offset = data;
                end
                cwmf_pkg::CFG_LEN: begin
                    // Any length write restarts the window from its first entry.
                    length    = data[cwmf_pkg::LEN_W-1:0];
                    next_slot = 0;
                    filled    = 0;
                end
                cwmf_pkg::CFG_MEDIAN: begin
                    median = data[0];
                end
            endcase
        endfunction

        function q88_t calibrate(q88_t x);
            longint prod;
            longint y;
            prod = longint'(x) * longint'(gain) + longint'(cwmf_pkg::CAL_HALF);
            y = (prod >>> cwmf_pkg::CAL_FRAC) + longint'(offset);
            if (y > cwmf_pkg::SAT_MAX) y = cwmf_pkg::SAT_MAX;
            if (y < cwmf_pkg::SAT_MIN) y = cwmf_pkg::SAT_MIN;
            return y[cwmf_pkg::DW-1:0];
        endfunction

        function q88_t window_average(int unsigned n);
            int total;
            int i;
            total = 0;
            for (i = 0; i < n; i++) total += store[i];
            total = total / int'(n);
            return total[cwmf_pkg::DW-1:0];
        endfunction

        function q88_t window_middle(int unsigned n);
            q88_t sorted [WIN_MAX];
            q88_t key;
            int   i;
            int   j;
            for (i = 0; i < n; i++) sorted[i] = store[i];
            for (i = 1; i < n; i++) begin
                key = sorted[i];
                j = i;
                while (j > 0 && sorted[j-1] > key) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = key;
            end
            return sorted[n/2];
        endfunction

        function void take_sample(q88_t x);
            int unsigned  span;
            filter_pair_t entry;
            if (length == 0) span = 1;
            else if (length > WIN_MAX) span = WIN_MAX;
            else span = length;
            if (next_slot >= span) next_slot = 0;
            if (filled > span) filled = span;
            entry.cal = calibrate(x);
            store[next_slot] = entry.cal;
            next_slot = (next_slot + 1) % span;
            if (filled < span) filled++;
            entry.filt = median ? window_middle(filled) : window_average(filled);
            expected_pairs.push_back(entry);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100) $display("%s", msg);
        endtask

        task compare_result(q88_t cal, q88_t filt);
            filter_pair_t want;
            if (expected_pairs.size() == 0) begin
                report($sformatf("unexpected result: calibrated %0d filtered %0d", cal, filt));
                return;
            end
            want = expected_pairs.pop_front();
            if (cal !== want.cal)
                report($sformatf("calibrated mismatch: got %0d, wanted %0d", cal, want.cal));
            if (filt !== want.filt)
                report($sformatf("filtered mismatch: got %0d, wanted %0d (calibrated %0d)",
                                 filt, want.filt, want.cal));
        endtask
    endclass

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    q88_t                             sample    = '0;
    logic                             out_ready = 1'b0;
    logic                             cfg_we    = 1'b0;
    cwmf_pkg::t_cfg_idx               cfg_idx   = cwmf_pkg::CFG_GAIN;
    logic [cwmf_pkg::CFG_W-1:0]       cfg_data  = '0;
    logic                             in_ready;
    logic                             out_valid;
    q88_t                             calibrated;
    q88_t                             filtered;

    bit                               calm = 1'b0;
    int                               sent = 0;
    cal_filter_tracker                sb   = new();

    calibrated_window_mean_median_filter #(
        .MAX_WINDOW(WIN_MAX)
    ) uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_sample     (sample),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_calibrated (calibrated),
        .o_filtered   (filtered),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic q88_t pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            case ($urandom_range(0, 3))
                0: return 16'sh7FFF;
                1: return 16'sh8000;
                2: return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        if (r < 60) return q88_t'($urandom_range(0, 60 * 256) - 10 * 256);
        return q88_t'($urandom());
    endfunction

    task automatic send_sample(input q88_t value);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 32) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.take_sample(value);
        sent++;
    endtask

    task automatic put_reg(input cwmf_pkg::t_cfg_idx idx,
                           input logic [cwmf_pkg::CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_settings(input logic [cwmf_pkg::GAIN_W-1:0] g, input q88_t o,
                                  input logic [cwmf_pkg::LEN_W-1:0] l, input bit m,
                                  input bit restart);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        put_reg(cwmf_pkg::CFG_GAIN, g);
        put_reg(cwmf_pkg::CFG_OFFSET, o);
        if (restart) put_reg(cwmf_pkg::CFG_LEN, {{(cwmf_pkg::CFG_W-cwmf_pkg::LEN_W){1'b0}}, l});
        put_reg(cwmf_pkg::CFG_MEDIAN, {{(cwmf_pkg::CFG_W-1){1'b0}}, m});
        cfg_we <= 1'b0;
    endtask

    initial begin : result_side
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) sb.compare_result(calibrated, filtered);
            out_ready <= calm || ($urandom_range(0, 99) >= 32);
        end
    end

    initial begin : stimulus
        logic [cwmf_pkg::GAIN_W-1:0] g;
        q88_t                        o;
        logic [cwmf_pkg::LEN_W-1:0]  l;
        int                          phase;
        int                          k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings after reset, with the window wrapping under the moving mean.
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
        send_sample(16'sh0001);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);

        // A gain of one half makes odd samples fall on rounding ties; even counts in the median.
        apply_settings(16'd8192, 16'sh0000, 5'd4, 1'b1, 1'b1);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
        send_sample(16'sh0003);
        send_sample(16'shFFFD);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);

        // Saturation at both ends with the widest window.
        apply_settings(16'hFFFF, 16'sh7FFF, 5'd16, 1'b0, 1'b1);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0064);

        // A zero length acts as one; a zero gain leaves only the offset.
        apply_settings(16'd0, 16'sh8000, 5'd0, 1'b1, 1'b1);
        send_sample(16'sh04D2);
        send_sample(16'shFFFB);

        // A length beyond the window depth acts as the full depth.
        apply_settings(16'd16384, 16'sh0000, 5'd31, 1'b1, 1'b1);
        repeat (4) send_sample(pick_sample());

        apply_settings(cwmf_pkg::GAIN_RST, cwmf_pkg::OFFSET_RST, 5'd1, 1'b0, 1'b1);
        send_sample(pick_sample());
        send_sample(pick_sample());

        phase = 0;
        while (sent < 480) begin
            calm = (phase >= 6 && phase < 9);
            k = $urandom_range(0, 99);
            if (k < 15) begin
                case ($urandom_range(0, 3))
                    0: g = '0;
                    1: g = '1;
                    2: g = 16'd16384;
                    default: g = 16'd8192;
                endcase
            end else if (k < 60) begin
                g = 16'd14336 + 16'($urandom_range(0, 4096));
            end else begin
                g = 16'($urandom());
            end
            k = $urandom_range(0, 99);
            if (k < 15) begin
                case ($urandom_range(0, 2))
                    0: o = 16'sh8000;
                    1: o = 16'sh7FFF;
                    default: o = '0;
                endcase
            end else if (k < 60) begin
                o = q88_t'($urandom_range(0, 2048) - 1024);
            end else begin
                o = q88_t'($urandom());
            end
            k = $urandom_range(0, 99);
            if (k < 12) begin
                case ($urandom_range(0, 3))
                    0: l = 5'd0;
                    1: l = 5'd17;
                    2: l = 5'd31;
                    default: l = 5'($urandom_range(17, 31));
                endcase
            end else begin
                l = 5'($urandom_range(1, 16));
            end
            apply_settings(g, o, l, 1'($urandom_range(0, 1)),
                           phase == 0 || $urandom_range(0, 99) < 60);
            repeat ($urandom_range(8, 40)) send_sample(pick_sample());
            phase++;
        end

        calm = 1'b0;
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.errors == 0) begin
            $display("calibrated_window_mean_median_filter verification clean");
        end else begin
            $display("calibrated_window_mean_median_filter verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("calibrated_window_mean_median_filter verification failed");
        $finish;
    end

endmodule
